[rtl/fpa_pkg.sv]
// fpa_pkg: shared types and constants for the fixed-point alu
// word widths, operation codes and the lane record passed along the divider chain
// no dependencies
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int REM_W     = WORD_W + 1;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_MIN      = 4'd4,
    FN_MAX      = 4'd5,
    FN_INC      = 4'd6,
    FN_DEC      = 4'd7,
    FN_TO_INT   = 4'd8,
    FN_FROM_INT = 4'd9
  } fpa_func_t;

  typedef struct packed {
    logic              valid;
    logic [3:0]        func;
    logic [WORD_W-1:0] res;
    logic              less;
    logic              equal;
    logic              greater;
    logic              dz;
    logic              neg;
    logic [REM_W-1:0]  rem;
    logic [NUM_W-1:0]  qn;
    logic [WORD_W-1:0] den;
  } fpa_lane_t;

endpackage

[rtl/fpa_front.sv]
// fpa_front: two input stages, magnitude multiply then result and divider setup
// depends on fpa_pkg
module fpa_front import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [3:0]               in_func,
  input  logic signed [WORD_W-1:0] in_a,
  input  logic signed [WORD_W-1:0] in_b,
  output fpa_lane_t                lane_o
);

  logic              va_r;
  logic [3:0]        func_r;
  logic [WORD_W-1:0] a_r, b_r;
  logic [PROD_W-1:0] prod_r;
  logic [WORD_W-1:0] amag, bmag;

  assign amag = in_a[WORD_W-1] ? (~in_a + 1'b1) : in_a;
  assign bmag = in_b[WORD_W-1] ? (~in_b + 1'b1) : in_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      func_r <= in_func;
      a_r    <= in_a;
      b_r    <= in_b;
      prod_r <= amag * bmag;
    end
  end

  fpa_lane_t         lane_nxt, lane_r;
  logic              less, equal, greater, neg;
  logic [PROD_W-1:0] mul_mag;
  logic [WORD_W-1:0] mul_res, amag_r, bmag_r;

  always_comb begin
    less    = $signed(a_r) < $signed(b_r);
    equal   = a_r == b_r;
    greater = $signed(a_r) > $signed(b_r);
    neg     = a_r[WORD_W-1] ^ b_r[WORD_W-1];
    amag_r  = a_r[WORD_W-1] ? (~a_r + 1'b1) : a_r;
    bmag_r  = b_r[WORD_W-1] ? (~b_r + 1'b1) : b_r;
    // round half away from zero on the magnitude
    mul_mag = (prod_r + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_res = neg ? (~mul_mag[WORD_W-1:0] + 1'b1) : mul_mag[WORD_W-1:0];

    lane_nxt         = '0;
    lane_nxt.valid   = va_r;
    lane_nxt.func    = func_r;
    lane_nxt.less    = less;
    lane_nxt.equal   = equal;
    lane_nxt.greater = greater;
    lane_nxt.neg     = neg;
    lane_nxt.den     = bmag_r;
    lane_nxt.qn      = {amag_r, {FRAC_BITS{1'b0}}};
    lane_nxt.rem     = '0;
    lane_nxt.dz      = (func_r == FN_DIV) && (b_r == '0);
    unique case (func_r)
      FN_ADD:      lane_nxt.res = a_r + b_r;
      FN_SUB:      lane_nxt.res = a_r - b_r;
      FN_MUL:      lane_nxt.res = mul_res;
      FN_MIN:      lane_nxt.res = less ? a_r : b_r;
      FN_MAX:      lane_nxt.res = greater ? a_r : b_r;
      FN_INC:      lane_nxt.res = a_r + 1'b1;
      FN_DEC:      lane_nxt.res = a_r - 1'b1;
      FN_TO_INT:   lane_nxt.res = WORD_W'($signed(a_r) >>> FRAC_BITS);
      FN_FROM_INT: lane_nxt.res = a_r << FRAC_BITS;
      default:     lane_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.func    <= lane_nxt.func;
      lane_r.res     <= lane_nxt.res;
      lane_r.less    <= lane_nxt.less;
      lane_r.equal   <= lane_nxt.equal;
      lane_r.greater <= lane_nxt.greater;
      lane_r.dz      <= lane_nxt.dz;
      lane_r.neg     <= lane_nxt.neg;
      lane_r.rem     <= lane_nxt.rem;
      lane_r.qn      <= lane_nxt.qn;
      lane_r.den     <= lane_nxt.den;
    end
  end

  assign lane_o = lane_r;

endmodule

[rtl/fpa_div_cell.sv]
// fpa_div_cell: one restoring-division step, one quotient bit per cell
// depends on fpa_pkg
module fpa_div_cell import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  fpa_lane_t lane_i,
  output fpa_lane_t lane_o
);

  fpa_lane_t        lane_nxt, lane_r;
  logic [REM_W-1:0] rem_sh;
  logic             ge;

  always_comb begin
    rem_sh       = {lane_i.rem[REM_W-2:0], lane_i.qn[NUM_W-1]};
    ge           = rem_sh >= {1'b0, lane_i.den};
    lane_nxt     = lane_i;
    lane_nxt.rem = ge ? (rem_sh - {1'b0, lane_i.den}) : rem_sh;
    // dividend bits leave at the top, quotient bits enter at the bottom
    lane_nxt.qn  = {lane_i.qn[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.func    <= lane_nxt.func;
      lane_r.res     <= lane_nxt.res;
      lane_r.less    <= lane_nxt.less;
      lane_r.equal   <= lane_nxt.equal;
      lane_r.greater <= lane_nxt.greater;
      lane_r.dz      <= lane_nxt.dz;
      lane_r.neg     <= lane_nxt.neg;
      lane_r.rem     <= lane_nxt.rem;
      lane_r.qn      <= lane_nxt.qn;
      lane_r.den     <= lane_nxt.den;
    end
  end

  assign lane_o = lane_r;

endmodule

[rtl/fixed_point_q24_8_alu_unit.sv]
// Signed Q24.8 fixed-point alu. One operation is accepted every cycle while in_stall
// is low. Each operation passes in turn through the two input
// stages, one division cell per quotient bit (32 + FRAC_BITS cells) and an output
// register. The whole pipeline advances together and halts only while a finished
// result is held under out_stall. Product and quotient round half away from zero;
// all results wrap to 32 bits; a divide by zero returns zero with its flag set.
// depends on fpa_pkg, fpa_front, fpa_div_cell
module fixed_point_q24_8_alu_unit import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_func,
  input  logic signed [WORD_W-1:0] in_operand_a,
  input  logic signed [WORD_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_result,
  output logic                     out_a_less,
  output logic                     out_a_equal,
  output logic                     out_a_greater,
  output logic                     out_divide_by_zero
);

  logic      en;
  fpa_lane_t chain [NUM_W+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_a     (in_operand_a),
    .in_b     (in_operand_b),
    .lane_o   (chain[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .lane_i (chain[i]),
      .lane_o (chain[i+1])
    );
  end

  fpa_lane_t         last;
  logic [WORD_W-1:0] q_rnd, div_res, res_nxt;
  logic              up;

  assign last = chain[NUM_W];

  always_comb begin
    // round up when twice the remainder reaches the divisor
    up      = {last.rem, 1'b0} >= {2'b00, last.den};
    q_rnd   = last.qn[WORD_W-1:0] + WORD_W'(up);
    div_res = last.neg ? (~q_rnd + 1'b1) : q_rnd;
    if (last.func == FN_DIV) begin
      res_nxt = last.dz ? '0 : div_res;
    end else begin
      res_nxt = last.res;
    end
  end

  logic              valid_r;
  logic [WORD_W-1:0] result_r;
  logic              less_r, equal_r, greater_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= last.valid;
    end
    if (en) begin
      result_r  <= res_nxt;
      less_r    <= last.less;
      equal_r   <= last.equal;
      greater_r <= last.greater;
      dz_r      <= last.dz;
    end
  end

  assign out_valid          = valid_r;
  assign out_result         = result_r;
  assign out_a_less         = less_r;
  assign out_a_equal        = equal_r;
  assign out_a_greater      = greater_r;
  assign out_divide_by_zero = dz_r;

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not exclusive");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result == '0)
    else $error("divide by zero gave nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

[test/tb.sv]
// tb: self-checking testbench for fixed_point_q24_8_alu_unit
// predicts each result from the operation code and operands, checks in order
// depends on fpa_pkg and the alu rtl
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  localparam int LATENCY   = NUM_W + 3;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              less;
    logic              equal;
    logic              greater;
    logic              dz;
  } alu_out_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [3:0]               in_func;
  logic signed [WORD_W-1:0] in_operand_a;
  logic signed [WORD_W-1:0] in_operand_b;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_result;
  logic                     out_a_less;
  logic                     out_a_equal;
  logic                     out_a_greater;
  logic                     out_divide_by_zero;

  alu_out_t expected_q[$];
  int       error_cnt;
  int       cycle_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;

  fixed_point_q24_8_alu_unit u_top (.*);

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round-half-away-from-zero helpers built on 64-bit magnitudes
  function automatic logic [WORD_W-1:0] signed_wrap(logic [63:0] mag, logic neg);
    logic [63:0] v;
    v = neg ? (64'd0 - mag) : mag;
    return v[WORD_W-1:0];
  endfunction

  function automatic alu_out_t alu_predict(logic [3:0] fn, logic signed [WORD_W-1:0] a,
                                           logic signed [WORD_W-1:0] b);
    alu_out_t    r;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] prod;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rm;
    logic        neg;
    ma  = a < 0 ? 64'd0 - 64'(signed'(a)) : 64'(signed'(a));
    mb  = b < 0 ? 64'd0 - 64'(signed'(b)) : 64'(signed'(b));
    neg = (a < 0) != (b < 0);
    r   = '0;
    case (fn)
      FN_ADD:      r.result = a + b;
      FN_SUB:      r.result = a - b;
      FN_MUL: begin
        prod     = ma * mb;
        prod     = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r.result = signed_wrap(prod, neg);
      end
      FN_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = ma << FRAC_BITS;
          q   = num / mb;
          rm  = num % mb;
          if (2 * rm >= mb) q = q + 1;
          r.result = signed_wrap(q, neg);
        end
      end
      FN_MIN:      r.result = a < b ? a : b;
      FN_MAX:      r.result = a > b ? a : b;
      FN_INC:      r.result = a + 1;
      FN_DEC:      r.result = a - 1;
      FN_TO_INT:   r.result = a >>> FRAC_BITS;
      FN_FROM_INT: r.result = a << FRAC_BITS;
      default:     r.result = '0;
    endcase
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall and result checking
  always @(posedge clk) begin
    alu_out_t exp_r;
    alu_out_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_result, out_a_less, out_a_equal, out_a_greater, out_divide_by_zero};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.result !== exp_r.result)
            $display("%0t: result expected %h actual %h", $time, exp_r.result, got.result);
          if (got.less !== exp_r.less)
            $display("%0t: a_less expected %b actual %b", $time, exp_r.less, got.less);
          if (got.equal !== exp_r.equal)
            $display("%0t: a_equal expected %b actual %b", $time, exp_r.equal, got.equal);
          if (got.greater !== exp_r.greater)
            $display("%0t: a_greater expected %b actual %b", $time, exp_r.greater,
                     got.greater);
          if (got.dz !== exp_r.dz)
            $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz, got.dz);
          if (got !== exp_r) error_cnt++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one transfer on the input channel, with a random idle gap first
  task automatic send_op(logic [3:0] fn, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(alu_predict(fn, a, b));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(5))
      0:       return $urandom_range(1023);
      1:       return -$urandom_range(1023);
      2:       return $urandom & 32'h0000_ffff;
      3:       return {{16{1'b1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [WORD_W-1:0] ext[5];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
    for (int f = 0; f < 16; f++) send_op(4'(f), ext[f % 5], ext[(f + 2) % 5]);
    send_op(FN_DIV, 32'h0000_0300, 32'h0);          // divide by zero
    send_op(FN_DIV, 32'h8000_0000, 32'hffff_ffff);  // quotient overflow wraps
    send_op(FN_MUL, 32'h8000_0000, 32'h8000_0000);  // product overflow wraps
    send_op(FN_MUL, 32'h0000_0001, 32'h0000_0080);  // exact half rounds away
    send_op(FN_MUL, 32'hffff_ffff, 32'h0000_0080);  // negative half
    send_op(FN_DIV, 32'h0000_0001, 32'h0000_0200);  // quotient half
    send_op(FN_TO_INT, 32'hffff_ff01, 32'h0);       // rounds toward minus infinity
    send_op(FN_MIN, 32'h1234, 32'h1234);
    go_idle();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    logic [WORD_W-1:0] a;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      a = rand_word();
      // equal operands now and then so the equal flag toggles
      send_op($urandom_range(15) < 13 ? 4'($urandom_range(9)) : 4'($urandom_range(15)), a,
              $urandom_range(9) == 0 ? a : rand_word());
    end
    go_idle();
  endtask

  initial begin
    error_cnt      = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = '0;
    in_operand_a   = '0;
    in_operand_b   = '0;
    out_stall      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 76, 0);
    test_random(250, 0, 76);
    test_random(250, 15, 15);
    send_idle_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_cell.sv
rtl/fixed_point_q24_8_alu_unit.sv
test/tb.sv
